// ===== rtl/bcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Cartridge mapper package
// Codes, widths and clock limits shared by the banked cartridge mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package bcm_pkg;

    localparam int ROM_BANK_BITS  = 7;
    localparam int RAM_BANK_COUNT = 4;
    localparam int TICK_W         = 24;
    localparam int MAP_W          = 21;
    localparam int CLK_REGS       = 5;

    localparam logic [TICK_W-1:0] TPS_RESET = 24'd1048576;

    localparam logic [3:0] WE_KEY      = 4'hA;
    localparam logic [7:0] SEL_CLK_LO  = 8'h08;
    localparam logic [7:0] SEL_CLK_HI  = 8'h0C;
    localparam logic [7:0] SEC_MAX     = 8'd59;
    localparam logic [7:0] MIN_MAX     = 8'd59;
    localparam logic [7:0] HOUR_MAX    = 8'd23;
    localparam logic [7:0] DAYL_MAX    = 8'd255;

    localparam int CLK_SEC  = 0;
    localparam int CLK_MIN  = 1;
    localparam int CLK_HOUR = 2;
    localparam int CLK_DAYL = 3;
    localparam int CLK_DAYH = 4;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_ROM  = 2'd1,
        TGT_RAM  = 2'd2,
        TGT_CLK  = 2'd3
    } t_target;

    typedef enum logic [1:0] {
        LATCH_IDLE      = 2'd0,
        LATCH_ARMING    = 2'd1,
        LATCH_HELD      = 2'd2,
        LATCH_RELEASING = 2'd3
    } t_latch;

    typedef logic [7:0] t_clock [CLK_REGS];

endpackage

`default_nettype wire

// ===== rtl/banked_cartridge_mapper_with_rtc_core.sv =====
// ----------------------------------------------------------------------------
// Banked cartridge mapper with real-time clock
// Decodes bus reads and writes against the cartridge map, keeps the bank
// selects and the latch sequence, and runs a seconds to days clock on ticks.
// ----------------------------------------------------------------------------
//  Channel   Signals                                   Direction
//  input     i_valid, o_stall, i_opcode/address/data   in
//  output    o_valid, i_stall, o_target ... o_access_error  out
//  config    i_cfg_wr_en, i_cfg_data                   in
//
// Each word is decoded and its state update made in the cycle it is
// accepted; the result is held in the output register from the next cycle.
// One word is taken per cycle unless the output register is full and stalled.
// Synchronous reset puts all but the output data to documented values.
// ----------------------------------------------------------------------------
`default_nettype none

module banked_cartridge_mapper_with_rtc_core
    import bcm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [TICK_W-1:0] i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_opcode,
    input  wire logic [15:0]       i_address,
    input  wire logic [7:0]        i_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [1:0]             o_target,
    output logic [MAP_W-1:0]       o_mapped_address,
    output logic [7:0]             o_read_value,
    output logic                   o_ram_write_strobe,
    output logic                   o_access_error
);

    logic [TICK_W-1:0]        r_tps;
    logic [ROM_BANK_BITS-1:0] r_rom_bank, n_rom_bank;
    logic [3:0]               r_ram_sel, n_ram_sel;
    logic                     r_we, n_we;
    t_latch                   r_latch, n_latch;
    logic [TICK_W-1:0]        r_tick, n_tick;
    t_clock                   r_live, n_live;
    t_clock                   r_snap, n_snap;

    logic                     r_out_valid;
    t_target                  r_target, n_target;
    logic [MAP_W-1:0]         r_mapped, n_mapped;
    logic [7:0]               r_rval, n_rval;
    logic                     r_strobe, n_strobe;
    logic                     r_err, n_err;

    logic                     accept;
    t_opcode                  op;
    logic                     sel_clk;
    logic [2:0]               clk_idx;
    logic [TICK_W-1:0]        tick_inc;
    logic                     is_latch_wr;
    logic [MAP_W-1:0]         ram_map;
    t_clock                   adv;

    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;
    assign op      = t_opcode'(i_opcode);
    assign sel_clk = ({4'd0, r_ram_sel} >= SEL_CLK_LO) && ({4'd0, r_ram_sel} <= SEL_CLK_HI);
    assign clk_idx = r_ram_sel[2:0];
    assign tick_inc = r_tick + 1'b1;
    assign ram_map = MAP_W'({r_ram_sel, i_address[12:0]});
    assign is_latch_wr = (op == OP_WRITE) && (i_address[15:13] == 3'b011);

    // One second step of the running clock.
    always_comb begin
        adv = r_live;
        if (r_live[CLK_SEC] != SEC_MAX) begin
            adv[CLK_SEC] = r_live[CLK_SEC] + 8'd1;
        end else begin
            adv[CLK_SEC] = 8'd0;
            if (r_live[CLK_MIN] != MIN_MAX) begin
                adv[CLK_MIN] = r_live[CLK_MIN] + 8'd1;
            end else begin
                adv[CLK_MIN] = 8'd0;
                if (r_live[CLK_HOUR] != HOUR_MAX) begin
                    adv[CLK_HOUR] = r_live[CLK_HOUR] + 8'd1;
                end else begin
                    adv[CLK_HOUR] = 8'd0;
                    if (r_live[CLK_DAYL] != DAYL_MAX) begin
                        adv[CLK_DAYL] = r_live[CLK_DAYL] + 8'd1;
                    end else begin
                        adv[CLK_DAYL] = 8'd0;
                        adv[CLK_DAYH] = {r_live[CLK_DAYH][7] | r_live[CLK_DAYH][0],
                                         r_live[CLK_DAYH][6:1], ~r_live[CLK_DAYH][0]};
                    end
                end
            end
        end
    end

    // Latch sequence next state.
    always_comb begin
        n_latch = r_latch;
        if (accept && is_latch_wr) begin
            case (r_latch)
                LATCH_IDLE:      if (i_data == 8'd0) n_latch = LATCH_ARMING;
                LATCH_ARMING:    if (i_data == 8'd1) n_latch = LATCH_HELD;
                LATCH_HELD:      if (i_data == 8'd0) n_latch = LATCH_RELEASING;
                LATCH_RELEASING: if (i_data == 8'd1) n_latch = LATCH_IDLE;
                default:         n_latch = r_latch;
            endcase
        end
    end

    // Snapshot copy on the step into the held phase.
    always_comb begin
        n_snap = r_snap;
        if (accept && is_latch_wr && r_latch == LATCH_ARMING && i_data == 8'd1) begin
            n_snap = r_live;
        end
    end

    always_comb begin
        n_rom_bank = r_rom_bank;
        n_ram_sel  = r_ram_sel;
        n_we       = r_we;
        n_tick     = r_tick;
        n_live     = r_live;
        n_target   = TGT_NONE;
        n_mapped   = '0;
        n_rval     = 8'd0;
        n_strobe   = 1'b0;
        n_err      = 1'b0;
        case (op)
            OP_READ: begin
                if (!i_address[15]) begin
                    n_target = TGT_ROM;
                    if (!i_address[14]) begin
                        n_mapped = MAP_W'(i_address[13:0]);
                    end else begin
                        n_mapped = MAP_W'({r_rom_bank, i_address[13:0]});
                    end
                end else if (i_address[15:13] == 3'b101) begin
                    if (sel_clk) begin
                        n_target = TGT_CLK;
                        n_rval = (r_latch == LATCH_HELD || r_latch == LATCH_RELEASING)
                                 ? r_snap[clk_idx] : r_live[clk_idx];
                    end else begin
                        n_target = TGT_RAM;
                        n_mapped = ram_map;
                    end
                end
            end
            OP_WRITE: begin
                if (i_address[15:13] == 3'b000) begin
                    n_we = (i_data[3:0] == WE_KEY);
                end else if (i_address[15:13] == 3'b001) begin
                    n_rom_bank = (i_data[ROM_BANK_BITS-1:0] == '0)
                                 ? ROM_BANK_BITS'(1) : i_data[ROM_BANK_BITS-1:0];
                end else if (i_address[15:13] == 3'b010) begin
                    if ((i_data >= SEL_CLK_LO && i_data <= SEL_CLK_HI)
                        || i_data < 8'(RAM_BANK_COUNT)) begin
                        n_ram_sel = i_data[3:0];
                    end else begin
                        n_err = 1'b1;
                    end
                end else if (i_address[15:13] == 3'b011) begin
                    n_err = 1'b0;
                end else if (i_address[15:13] == 3'b101 && r_we) begin
                    if (sel_clk) begin
                        n_target = TGT_CLK;
                        n_live[clk_idx] = i_data;
                    end else begin
                        n_target = TGT_RAM;
                        n_mapped = ram_map;
                        n_strobe = 1'b1;
                    end
                end else begin
                    n_err = 1'b1;
                end
            end
            OP_TICK: begin
                if (tick_inc >= r_tps) begin
                    n_tick = '0;
                    n_live = adv;
                end else begin
                    n_tick = tick_inc;
                end
            end
            default: begin
                n_err = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps       <= TPS_RESET;
            r_rom_bank  <= ROM_BANK_BITS'(1);
            r_ram_sel   <= 4'd0;
            r_we        <= 1'b0;
            r_latch     <= LATCH_IDLE;
            r_tick      <= '0;
            r_live      <= '{default: 8'd0};
            r_snap      <= '{default: 8'd0};
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tps <= i_cfg_data;
            end
            if (accept) begin
                r_rom_bank <= n_rom_bank;
                r_ram_sel  <= n_ram_sel;
                r_we       <= n_we;
                r_tick     <= n_tick;
                r_live     <= n_live;
            end
            r_latch <= n_latch;
            r_snap  <= n_snap;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_target <= n_target;
            r_mapped <= n_mapped;
            r_rval   <= n_rval;
            r_strobe <= n_strobe;
            r_err    <= n_err;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_target           = r_target;
    assign o_mapped_address   = r_mapped;
    assign o_read_value       = r_rval;
    assign o_ram_write_strobe = r_strobe;
    assign o_access_error     = r_err;

    a_bank_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rom_bank != '0)
        else $error("ROM bank register holds zero");

    a_strobe_ram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ram_write_strobe) |-> (o_target == TGT_RAM && !o_access_error))
        else $error("RAM write strobe without a RAM target");

    a_latch_by_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_latch != $past(r_latch))
            |-> $past(accept && op == OP_WRITE))
        else $error("Latch phase moved without a bus write");

    a_sel_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sel_clk || ({4'd0, r_ram_sel} < 8'(RAM_BANK_COUNT)))
        else $error("RAM select holds an unknown value");

endmodule

`default_nettype wire
